// ===== rtl/bot_pkg.sv =====
// ---------------------------------------------------------------------------
// Box overlap tracker package
// Operation codes, sequencer states and shared sizes.
// ---------------------------------------------------------------------------
package bot_pkg;

  localparam int MAX_BOXES_DEF = 16;
  localparam int FRAC_BITS_DEF = 4;
  localparam int ENTRY_W = 64;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_STORE = 2'd1,
    OP_TRACK = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_GEOM,
    ST_MUL,
    ST_DIV,
    ST_CMP,
    ST_FREAD,
    ST_FWAIT,
    ST_BLEND,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/bot_ram.sv =====
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module bot_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/bot_div.sv =====
// ---------------------------------------------------------------------------
// Ratio divider
// Restoring divider, one quotient bit per cycle, 48-bit dividend.
// ---------------------------------------------------------------------------
module bot_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [47:0] quotient
);
  logic [32:0] rem;
  logic [47:0] quo;
  logic [5:0]  cnt;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[47]};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd48;
      rem  <= '0;
      quo  <= dividend;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= trial - {1'b0, divisor};
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[46:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end
endmodule

// ===== rtl/box_overlap_tracker.sv =====
// ---------------------------------------------------------------------------
// Box overlap tracker
// Two tables of stored boxes; a track scores each stored box of its side
// and blends the current box with the best-scoring one, if any.
// ---------------------------------------------------------------------------
// Clear and store complete on acceptance; the next request is accepted the cycle after.
// A track reads, waits on, measures and multiplies each stored box, then runs
// a 48-step shared division and a compare; with a match it reads the best box
// back and blends it in. One request at a time, input held while a result waits.
// Reset empties both tables (counts to zero); entries are not cleared.
module box_overlap_tracker #(
  parameter int MAX_BOXES = bot_pkg::MAX_BOXES_DEF,
  parameter int FRAC_BITS = bot_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic               side,
  input  logic signed [15:0] box_left,
  input  logic signed [15:0] box_top,
  input  logic [14:0]        box_width,
  input  logic [14:0]        box_height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_left,
  output logic signed [15:0] out_top,
  output logic [14:0]        out_width,
  output logic [14:0]        out_height,
  output logic               matched,
  output logic [3:0]         match_slot,
  output logic [16:0]        best_overlap
);
  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam logic signed [19:0] ONE = 20'sd1 <<< FRAC_BITS;

  bot_pkg::state_t state, state_next;

  logic [CW-1:0] count [2];
  logic          rq_side;
  logic signed [15:0] cx, cy;
  logic [14:0]   cw, ch;
  logic [CW-1:0] idx;
  logic [16:0]   best;
  logic [AW-1:0] slot;
  logic          found;

  logic [bot_pkg::ENTRY_W-1:0] rdata [2];
  logic [bot_pkg::ENTRY_W-1:0] ent;
  logic [AW-1:0] raddr;
  logic [1:0]    we;
  logic [AW-1:0] waddr;

  logic signed [19:0] iw, ih;
  logic [31:0]   si, su;
  logic          div_start, div_busy;
  logic [47:0]   div_q;

  logic signed [15:0] px, py;
  logic [15:0]   pw, ph;
  logic signed [19:0] ar, br, ab, bb, iwc, ihc;
  logic [31:0]   area_a, area_b;
  logic signed [19:0] nw1, nw2, nw, nx, ny;
  logic [16:0]   score;

  for (genvar s = 0; s < 2; s++) begin : g_tab
    bot_ram #(.WIDTH(bot_pkg::ENTRY_W), .DEPTH(MAX_BOXES)) u_ram (
      .clk(clk), .we(we[s]), .waddr(waddr),
      .wdata({1'b0, box_height, 1'b0, box_width, box_top, box_left}),
      .raddr(raddr), .rdata(rdata[s])
    );
  end

  assign ent = rdata[rq_side];
  assign px  = ent[15:0];
  assign py  = ent[31:16];
  assign pw  = ent[47:32];
  assign ph  = ent[63:48];
  assign waddr = count[side][AW-1:0];
  assign raddr = (state inside {bot_pkg::ST_FREAD, bot_pkg::ST_FWAIT}) ? slot : idx[AW-1:0];
  assign in_ready = (state == bot_pkg::ST_IDLE);

  always_comb begin
    we = '0;
    if (in_valid && in_ready && operation == bot_pkg::OP_STORE
        && box_width != '0 && box_height != '0
        && count[side] < CW'(MAX_BOXES))
      we[side] = 1'b1;
  end

  // intersection geometry
  always_comb begin
    ar  = 20'(cx) + 20'(signed'({1'b0, cw}));
    br  = 20'(px) + 20'(signed'({1'b0, pw}));
    ab  = 20'(cy) + 20'(signed'({1'b0, ch}));
    bb  = 20'(py) + 20'(signed'({1'b0, ph}));
    iwc = ONE + ((ar < br) ? ar : br) - ((20'(cx) > 20'(px)) ? 20'(cx) : 20'(px));
    ihc = ONE + ((ab < bb) ? ab : bb) - ((20'(cy) > 20'(py)) ? 20'(cy) : 20'(py));
    area_a = 32'(cw) * 32'(ch);
    area_b = 32'(pw) * 32'(ph);
  end

  assign si = 32'(iw[17:0]) * 32'(ih[17:0]);

  assign score = (div_q > 48'd65536) ? 17'd65536 : div_q[16:0];

  // blend
  always_comb begin
    nw1 = (20'(signed'({1'b0, cw})) * 20'sd2 + 20'(signed'({1'b0, pw}))) >>> 1;
    nw2 = (20'(signed'({1'b0, ch})) * 20'sd2 + 20'(signed'({1'b0, ph}))) >>> 1;
    nw  = (nw1 > nw2) ? nw1 : nw2;
    nx  = (20'(cx) + 20'(px)
          + ((20'(signed'({1'b0, cw})) + 20'(signed'({1'b0, pw}))) >>> 1) - nw) >>> 1;
    ny  = (20'(cy) + 20'(py)
          + ((20'(signed'({1'b0, ch})) + 20'(signed'({1'b0, ph}))) >>> 1) - nw) >>> 1;
  end

  bot_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({si, 16'd0}), .divisor(su),
    .busy(div_busy), .quotient(div_q)
  );

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      bot_pkg::ST_IDLE:
        if (in_valid && operation == bot_pkg::OP_TRACK) state_next = bot_pkg::ST_READ;
      bot_pkg::ST_READ:
        if (cw == '0 || ch == '0 || idx >= count[rq_side])
          state_next = found ? bot_pkg::ST_FREAD : bot_pkg::ST_OUT;
        else state_next = bot_pkg::ST_WAIT;
      bot_pkg::ST_WAIT: state_next = bot_pkg::ST_GEOM;
      bot_pkg::ST_GEOM: state_next = bot_pkg::ST_MUL;
      bot_pkg::ST_MUL: begin
        if (su == '0) state_next = bot_pkg::ST_READ;
        else begin
          div_start  = 1'b1;
          state_next = bot_pkg::ST_DIV;
        end
      end
      bot_pkg::ST_DIV: if (!div_busy) state_next = bot_pkg::ST_CMP;
      bot_pkg::ST_CMP: state_next = bot_pkg::ST_READ;
      bot_pkg::ST_FREAD: state_next = bot_pkg::ST_FWAIT;
      bot_pkg::ST_FWAIT: state_next = bot_pkg::ST_BLEND;
      bot_pkg::ST_BLEND: state_next = bot_pkg::ST_OUT;
      bot_pkg::ST_OUT: if (!out_valid) state_next = bot_pkg::ST_IDLE;
      default: state_next = bot_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bot_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count[0]  <= '0;
      count[1]  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (in_valid && in_ready) begin
        if (operation == bot_pkg::OP_CLEAR) begin
          count[0] <= '0;
          count[1] <= '0;
        end
        if (we[side]) count[side] <= count[side] + CW'(1);
      end
      if (state == bot_pkg::ST_OUT && !out_valid) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bot_pkg::ST_IDLE: begin
        rq_side <= side;
        cx <= box_left;
        cy <= box_top;
        cw <= box_width;
        ch <= box_height;
        idx <= '0;
        best <= '0;
        slot <= '0;
        found <= 1'b0;
      end
      bot_pkg::ST_GEOM: begin
        iw <= (iwc > 0) ? iwc : '0;
        ih <= (ihc > 0) ? ihc : '0;
        su <= (area_a < area_b) ? area_a : area_b;
      end
      bot_pkg::ST_MUL: begin
        if (su == '0) idx <= idx + CW'(1);
      end
      bot_pkg::ST_CMP: begin
        if (score > best) begin
          best  <= score;
          slot  <= idx[AW-1:0];
          found <= 1'b1;
        end
        idx <= idx + CW'(1);
      end
      bot_pkg::ST_BLEND: begin
        cx <= (nx > 20'sd32767) ? 16'sd32767 : (nx < -20'sd32768) ? -16'sd32768 : nx[15:0];
        cy <= (ny > 20'sd32767) ? 16'sd32767 : (ny < -20'sd32768) ? -16'sd32768 : ny[15:0];
        cw <= (nw > 20'sd32767) ? 15'h7fff : nw[14:0];
        ch <= (nw > 20'sd32767) ? 15'h7fff : nw[14:0];
      end
      bot_pkg::ST_OUT: begin
        if (!out_valid) begin
          out_left     <= cx;
          out_top      <= cy;
          out_width    <= cw;
          out_height   <= ch;
          matched      <= found;
          match_slot   <= 4'(slot);
          best_overlap <= found ? best : '0;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (count[0] <= CW'(MAX_BOXES)) && (count[1] <= CW'(MAX_BOXES)))
    else $error("table count beyond capacity");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(best_overlap))
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == bot_pkg::ST_DIV)
    else $error("divider busy outside divide state");
  assert property (@(posedge clk) disable iff (rst)
    best <= 17'd65536)
    else $error("score above one");
endmodule

// ===== tb/box_overlap_tracker_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Box overlap tracker testbench
// Drives clear, store, track and no-op requests with random gaps and stalls. A
// scoreboard keeps its own copy of both box tables, predicts each tracked
// box and compares every returned result field by field.
// ---------------------------------------------------------------------------

typedef struct {
  logic signed [15:0] left;
  logic signed [15:0] top;
  logic [14:0]        width;
  logic [14:0]        height;
  logic               matched;
  logic [3:0]         slot;
  logic [16:0]        overlap;
} track_res_t;

class track_scoreboard;
  longint tab_x[2][16], tab_y[2][16], tab_w[2][16], tab_h[2][16];
  int count[2];
  track_res_t pending[$];
  int errors;
  int tracks;
  int match_total;

  function new();
    count[0] = 0;
    count[1] = 0;
    errors = 0;
    tracks = 0;
    match_total = 0;
  endfunction

  function longint fhalf(longint v);
    return v >>> 1;
  endfunction

  function longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function longint mn(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function longint mx(longint a, longint b);
    return a > b ? a : b;
  endfunction

  function void note_request(logic [1:0] op, logic sd, logic signed [15:0] bl,
                             logic signed [15:0] bt, logic [14:0] bw,
                             logic [14:0] bh);
    longint x, y, w, h, px, py, pw, ph, iw, ih, su, r, nw;
    longint best;
    int slot;
    bit found;
    track_res_t res;
    x = bl;
    y = bt;
    w = bw;
    h = bh;
    best = 0;
    slot = 0;
    found = 0;
    case (op)
      bot_pkg::OP_CLEAR: begin
        count[0] = 0;
        count[1] = 0;
      end
      bot_pkg::OP_STORE: begin
        if (w != 0 && h != 0 && count[sd] < 16) begin
          tab_x[sd][count[sd]] = x;
          tab_y[sd][count[sd]] = y;
          tab_w[sd][count[sd]] = w;
          tab_h[sd][count[sd]] = h;
          count[sd]++;
        end
      end
      bot_pkg::OP_TRACK: begin
        if (w * h > 0) begin
          for (int i = 0; i < count[sd]; i++) begin
            iw = mx(0, 16 + mn(x + w, tab_x[sd][i] + tab_w[sd][i]) - mx(x, tab_x[sd][i]));
            ih = mx(0, 16 + mn(y + h, tab_y[sd][i] + tab_h[sd][i]) - mx(y, tab_y[sd][i]));
            su = mn(w * h, tab_w[sd][i] * tab_h[sd][i]);
            r = ((iw * ih) << 16) / su;
            if (r > 65536) r = 65536;
            if (r > best) begin
              best = r;
              slot = i;
              found = 1;
            end
          end
        end
        if (found) begin
          px = tab_x[sd][slot];
          py = tab_y[sd][slot];
          pw = tab_w[sd][slot];
          ph = tab_h[sd][slot];
          nw = mx(fhalf(2 * w + pw), fhalf(2 * h + ph));
          x = fhalf(x + px + fhalf(w + pw) - nw);
          y = fhalf(y + py + fhalf(h + ph) - nw);
          w = nw;
          h = nw;
          match_total++;
        end
        res.left = sat(x, -32768, 32767);
        res.top = sat(y, -32768, 32767);
        res.width = sat(w, 0, 32767);
        res.height = sat(h, 0, 32767);
        res.matched = found;
        res.slot = slot;
        res.overlap = best;
        pending.push_back(res);
        tracks++;
      end
      default: ;
    endcase
  endfunction

  function void check_result(track_res_t got);
    track_res_t e;
    if (pending.size() == 0) begin
      $error("unexpected result left=%0d", got.left);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.left !== e.left) begin
      $error("out_left exp %0d got %0d", e.left, got.left); errors++;
    end
    if (got.top !== e.top) begin
      $error("out_top exp %0d got %0d", e.top, got.top); errors++;
    end
    if (got.width !== e.width) begin
      $error("out_width exp %0d got %0d", e.width, got.width); errors++;
    end
    if (got.height !== e.height) begin
      $error("out_height exp %0d got %0d", e.height, got.height); errors++;
    end
    if (got.matched !== e.matched) begin
      $error("matched exp %0d got %0d", e.matched, got.matched); errors++;
    end
    if (got.slot !== e.slot) begin
      $error("match_slot exp %0d got %0d", e.slot, got.slot); errors++;
    end
    if (got.overlap !== e.overlap) begin
      $error("best_overlap exp %0d got %0d", e.overlap, got.overlap); errors++;
    end
  endfunction
endclass

module box_overlap_tracker_test;
  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         operation = bot_pkg::OP_CLEAR;
  logic               side = 0;
  logic signed [15:0] box_left = 0;
  logic signed [15:0] box_top = 0;
  logic [14:0]        box_width = 0;
  logic [14:0]        box_height = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [15:0] out_left;
  logic signed [15:0] out_top;
  logic [14:0]        out_width;
  logic [14:0]        out_height;
  logic               matched;
  logic [3:0]         match_slot;
  logic [16:0]        best_overlap;

  track_scoreboard sb = new();
  bit calm = 0;
  bit hold_off = 0;
  int sent = 0;

  always #4 clk = ~clk;

  box_overlap_tracker u_dut (.*);

  function bit idle_now();
    return !calm && ($urandom_range(99) < 18);
  endfunction

  task automatic send(logic [1:0] op, logic sd, logic signed [15:0] bl,
                      logic signed [15:0] bt, logic [14:0] bw, logic [14:0] bh);
    while (idle_now()) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    operation <= op;
    side <= sd;
    box_left <= bl;
    box_top <= bt;
    box_width <= bw;
    box_height <= bh;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, sd, bl, bt, bw, bh);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  task automatic rand_req(bit sane);
    logic [1:0] op;
    logic signed [15:0] x, y;
    logic [14:0] w, h;
    int k;
    k = $urandom_range(99);
    op = k < 4 ? bot_pkg::OP_CLEAR : (k < 45 ? bot_pkg::OP_STORE :
         (k < 97 ? bot_pkg::OP_TRACK : bot_pkg::OP_NONE));
    if (sane) begin
      x = $urandom_range(1200) - 600;
      y = $urandom_range(1200) - 600;
      w = $urandom_range(800);
      h = $urandom_range(800);
      if ($urandom_range(19) == 0) w = 0;
    end else begin
      x = $urandom;
      y = $urandom;
      w = $urandom;
      h = $urandom;
    end
    send(op, $urandom_range(1), x, y, w, h);
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= !hold_off && !idle_now();
    if (!rst && out_valid && out_ready)
      sb.check_result('{out_left, out_top, out_width, out_height, matched,
                        match_slot, best_overlap});
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: empty tracks, extremes, zero-area cases, full table, ties.
    send(bot_pkg::OP_TRACK, 0, 0, 0, 100, 100);
    send(bot_pkg::OP_STORE, 0, 0, 0, 0, 50);
    send(bot_pkg::OP_STORE, 0, 0, 0, 50, 0);
    send(bot_pkg::OP_TRACK, 0, 0, 0, 0, 80);
    send(bot_pkg::OP_STORE, 1, -32768, -32768, 32767, 32767);
    send(bot_pkg::OP_TRACK, 1, 32767, 32767, 32767, 32767);
    send(bot_pkg::OP_TRACK, 1, -32768, -32768, 32767, 32767);
    send(bot_pkg::OP_NONE, 1, 16'h5555, 16'haaaa, 15'h2aaa, 15'h5555);
    send(bot_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
    for (int i = 0; i < 17; i++) send(bot_pkg::OP_STORE, 0, 0, 0, 160, 160);
    send(bot_pkg::OP_TRACK, 0, 8, 8, 160, 160);
    send(bot_pkg::OP_TRACK, 0, -32768, 32767, 1, 1);
    drain();
    // Pressure: stall results while requests keep coming.
    hold_off = 1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 20; i++) rand_req(1);
    join
    drain();
    calm = 1;
    for (int i = 0; i < 150; i++) rand_req(1);
    calm = 0;
    while (sent < 1300) rand_req($urandom_range(9) != 0);
    drain();
    $display("Sent %0d requests; %0d tracks checked, %0d matched a stored box.",
             sent, sb.tracks, sb.match_total);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #100000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== box_overlap_tracker.f =====
rtl/bot_pkg.sv
rtl/bot_ram.sv
rtl/bot_div.sv
rtl/box_overlap_tracker.sv
tb/box_overlap_tracker_test.sv
